/* rtl/core/ttsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ttsp_pkg;
   localparam int TagW = 32;
   localparam int InfoW = 25;
   localparam int PayW = 48;
   localparam logic [1:0] BOUND_EXACT = 2'd3;

   typedef enum logic {ACT_PROBE = 1'b0, ACT_STORE = 1'b1} action_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_READ  = 2'd1,
      BK_WRITE = 2'd2
   } back_state_type;

   typedef struct packed {
      logic        action;
      logic [63:0] key;
      logic [15:0] score;
      logic [1:0]  bound;
      logic [14:0] depth;
      logic [15:0] move;
      logic [15:0] eval;
   } cmd_type;

   typedef struct packed {
      logic        found;
      logic [15:0] score;
      logic [1:0]  bound;
      logic [14:0] depth;
      logic [15:0] move;
      logic [15:0] eval;
      logic [7:0]  age;
   } rsp_type;

   localparam int CmdW = $bits(cmd_type);
   localparam int RspW = $bits(rsp_type);
endpackage
`default_nettype wire

/* rtl/core/ttsp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module ttsp_fifo #(
   parameter int Width = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [Width-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [Width-1:0]      dout,
   output logic                  empty
);
   // two-entry queue
   logic [Width-1:0] slot_ff [2];
   logic             rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign dout = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      rd_in = rd_ff ^ do_pop;
      wr_in = wr_ff ^ do_push;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wr_ff] <= din;
   end
endmodule
`default_nettype wire

/* rtl/core/ttsp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ttsp_back #(
   parameter int SetBits = 12,
   parameter int Ways = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           generation,
   input  wire ttsp_pkg::cmd_type    cmd,
   input  wire logic                 cmd_empty,
   output logic                      cmd_pop,
   output ttsp_pkg::rsp_type         rsp,
   output logic                      rsp_push,
   input  wire logic                 rsp_full
);
   import ttsp_pkg::*;

   localparam int WayW = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int Depth = 1 << SetBits;
   localparam int EntW = TagW + InfoW + PayW;

   // one memory row per cluster: all ways read together
   logic [Ways*EntW-1:0] mem [Depth];
   logic [Ways*EntW-1:0] row_ff;
   logic [Ways*EntW-1:0] row_wr;
   logic [SetBits-1:0]   waddr;
   logic                 wen;

   back_state_type state_ff, state_in;
   logic [SetBits:0] clr_ff, clr_in;
   logic             clearing;

   logic [SetBits-1:0] set_idx;
   logic [TagW-1:0]    tag;
   assign set_idx = cmd.key[SetBits-1:0];
   assign tag = cmd.key[63:32];
   assign clearing = !clr_ff[SetBits];

   logic [TagW-1:0]  w_tag   [Ways];
   logic [14:0]      w_depth [Ways];
   logic [1:0]       w_bound [Ways];
   logic [7:0]       w_gen   [Ways];
   logic [PayW-1:0]  w_pay   [Ways];

   always_comb begin
      for (int w = 0; w < Ways; w++) begin
         w_tag[w]   = row_ff[w*EntW + InfoW + PayW +: TagW];
         w_depth[w] = row_ff[w*EntW + PayW +: 15];
         w_bound[w] = row_ff[w*EntW + PayW + 15 +: 2];
         w_gen[w]   = row_ff[w*EntW + PayW + 17 +: 8];
         w_pay[w]   = row_ff[w*EntW +: PayW];
      end
   end

   // hit search and victim choice over the read cluster
   logic             hit, fill;
   logic [WayW-1:0]  hit_way, fill_way, vic, tgt;
   logic [15:0]      move_wr;
   always_comb begin
      logic [2:0] c;
      hit = 1'b0;
      hit_way = '0;
      fill = 1'b0;
      fill_way = '0;
      vic = '0;
      for (int w = 0; w < Ways; w++) begin
         if (!hit && w_tag[w] == tag) begin
            hit = 1'b1;
            hit_way = WayW'(w);
         end
         if (!fill && (w_tag[w] == '0 || w_tag[w] == tag)) begin
            fill = 1'b1;
            fill_way = WayW'(w);
         end
      end
      for (int w = 1; w < Ways; w++) begin
         c = 3'd2;
         if (w_gen[vic] == generation) c = c + 3'd2;
         if (w_gen[w] == generation || w_bound[w] == BOUND_EXACT) c = c - 3'd2;
         if (w_depth[w] < w_depth[vic]) c = c + 3'd1;
         if (c > 3'd2) vic = WayW'(w);
      end
      tgt = fill ? fill_way : vic;
      move_wr = cmd.move;
      if (fill && cmd.move == 16'd0) move_wr = w_pay[fill_way][15:0];
   end

   always_comb begin
      row_wr = row_ff;
      waddr = set_idx;
      wen = 1'b0;
      if (clearing) begin
         row_wr = '0;
         waddr = clr_ff[SetBits-1:0];
         wen = 1'b1;
      end else if (state_ff == BK_WRITE && cmd.action == ACT_STORE) begin
         row_wr[32'(tgt)*EntW +: EntW] =
            {tag, generation, cmd.bound, cmd.depth, cmd.eval, cmd.score, move_wr};
         wen = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (!clearing && !cmd_empty && !rsp_full) state_in = BK_READ;
         BK_READ: state_in = BK_WRITE;
         BK_WRITE: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop = (state_ff == BK_WRITE);
      rsp_push = (state_ff == BK_WRITE);
      rsp = '0;
      if (cmd.action == ACT_PROBE && hit) begin
         rsp.found = 1'b1;
         rsp.score = w_pay[hit_way][31:16];
         rsp.move = w_pay[hit_way][15:0];
         rsp.eval = w_pay[hit_way][47:32];
         rsp.bound = w_bound[hit_way];
         rsp.depth = w_depth[hit_way];
         rsp.age = w_gen[hit_way];
      end
   end

   assign clr_in = clr_ff + (SetBits+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_in;
      end
      if (wen) mem[waddr] <= row_wr;
      row_ff <= mem[set_idx];
   end
endmodule
`default_nettype wire

/* rtl/core/transposition_table_store_probe.sv */
`timescale 1ns / 1ps
`default_nettype none
// Transposition table store/probe engine.
// Request channel (req_*): a transaction is taken when req_push is high and
// req_full is low; req_action selects probe or store. Transactions land in a
// two-deep command queue; the requester waits only when that queue is full.
// Response channel (rsp_*): one transaction per request, in order; the
// oldest sits on the rsp_ ports while rsp_empty is low and leaves on rsp_pop.
// The table is one memory row per cluster holding all ways. The back end
// reads the row into a register, compares tags and picks a victim, then
// writes the row back and posts the response (states READ, WRITE); it takes
// no new request until it is back in IDLE.
// Configuration: APB port; the register at address 0 is the search generation.
// After reset a clearing pass zeroes the table, one cluster per cycle, over all
// 2**SET_BITS clusters; requests queue but are not served meanwhile.
// If the response queue is full, the back end holds, and the command queue
// then fills and raises req_full.
module transposition_table_store_probe #(
   parameter int SET_BITS = 12,
   parameter int WAYS = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_action,
   input  wire logic [63:0]        req_position_key,
   input  wire logic signed [15:0] req_score_in,
   input  wire logic [1:0]         req_bound_in,
   input  wire logic signed [15:0] req_depth_in,
   input  wire logic [15:0]        req_move_in,
   input  wire logic signed [15:0] req_eval_in,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic                    rsp_found,
   output logic signed [15:0]      rsp_score_out,
   output logic [1:0]              rsp_bound_out,
   output logic [14:0]             rsp_depth_out,
   output logic [15:0]             rsp_move_out,
   output logic signed [15:0]      rsp_eval_out,
   output logic [7:0]              rsp_age_out,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic               paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import ttsp_pkg::*;

   // config register
   logic [7:0] gen_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == 1'b0) ? {24'd0, gen_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) gen_ff <= 8'd0;
      else if (psel && penable && pwrite && paddr == 1'b0) gen_ff <= pwdata[7:0];
   end

   // front: classify and clamp depth
   cmd_type req_cmd, q_cmd;
   always_comb begin
      req_cmd.action = req_action;
      req_cmd.key = req_position_key;
      req_cmd.score = req_score_in;
      req_cmd.bound = req_bound_in;
      req_cmd.depth = req_depth_in[15] ? 15'd0 : req_depth_in[14:0];
      req_cmd.move = req_move_in;
      req_cmd.eval = req_eval_in;
   end

   logic q_empty, q_pop, r_push, r_full;
   rsp_type r_data, r_out;

   ttsp_fifo #(.Width(CmdW)) u_cmdq (
      .clock(clock), .reset(reset), .push(req_push), .din(req_cmd),
      .full(req_full), .pop(q_pop), .dout(q_cmd), .empty(q_empty)
   );

   ttsp_back #(.SetBits(SET_BITS), .Ways(WAYS)) u_back (
      .clock(clock), .reset(reset), .generation(gen_ff), .cmd(q_cmd),
      .cmd_empty(q_empty), .cmd_pop(q_pop), .rsp(r_data), .rsp_push(r_push),
      .rsp_full(r_full)
   );

   ttsp_fifo #(.Width(RspW)) u_rspq (
      .clock(clock), .reset(reset), .push(r_push), .din(r_data),
      .full(r_full), .pop(rsp_pop), .dout(r_out), .empty(rsp_empty)
   );

   assign rsp_found = r_out.found;
   assign rsp_score_out = r_out.score;
   assign rsp_bound_out = r_out.bound;
   assign rsp_depth_out = r_out.depth;
   assign rsp_move_out = r_out.move;
   assign rsp_eval_out = r_out.eval;
   assign rsp_age_out = r_out.age;
endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import ttsp_pkg::*;

   localparam int SetBits = 12;
   localparam int Ways = 4;
   localparam int NumSets = 1 << SetBits;
   localparam int NumSlots = NumSets * Ways;
   localparam int RandomItems = 1500;
   localparam int DrainCycles = 20;
   localparam longint CycleLimit = 400000;

   typedef struct packed {
      logic        action;
      logic [63:0] key;
      logic [15:0] score;
      logic [1:0]  bound;
      logic [15:0] depth;
      logic [15:0] move;
      logic [15:0] eval;
   } probe_req_type;

   // One row of the directed table: the transaction, plus an optional
   // typed-in expected result that must agree with the table model.
   typedef struct {
      probe_req_type req;
      bit            has_fixed;
      rsp_type       fixed;
   } step_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_action = 1'b0;
   logic [63:0]        req_position_key = '0;
   logic signed [15:0] req_score_in = '0;
   logic [1:0]         req_bound_in = '0;
   logic signed [15:0] req_depth_in = '0;
   logic [15:0]        req_move_in = '0;
   logic signed [15:0] req_eval_in = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic               rsp_found;
   logic signed [15:0] rsp_score_out;
   logic [1:0]         rsp_bound_out;
   logic [14:0]        rsp_depth_out;
   logic [15:0]        rsp_move_out;
   logic signed [15:0] rsp_eval_out;
   logic [7:0]         rsp_age_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic               paddr = 1'b0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   transposition_table_store_probe #(.SET_BITS(SetBits), .WAYS(Ways)) i_dut (
      .clock, .reset, .req_push, .req_full, .req_action, .req_position_key,
      .req_score_in, .req_bound_in, .req_depth_in, .req_move_in, .req_eval_in,
      .rsp_empty, .rsp_pop, .rsp_found, .rsp_score_out, .rsp_bound_out,
      .rsp_depth_out, .rsp_move_out, .rsp_eval_out, .rsp_age_out,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #5 clock = ~clock;

   // Table model: tags, info and payload kept as separate fields per slot.
   logic [31:0] tt_tag   [NumSlots];
   logic [14:0] tt_depth [NumSlots];
   logic [1:0]  tt_bound [NumSlots];
   logic [7:0]  tt_age   [NumSlots];
   logic [15:0] tt_move  [NumSlots];
   logic [15:0] tt_score [NumSlots];
   logic [15:0] tt_eval  [NumSlots];
   logic [7:0]  generation = 8'd0;

   rsp_type expected_rsps[$];
   int      error_count = 0;
   longint  cycle_count = 0;
   int      push_idle_pct = 0;
   int      pop_idle_pct = 0;
   bit      done = 1'b0;

   task automatic report_mismatch(input string what, input logic [RspW-1:0] got,
                                  input logic [RspW-1:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // Advance the table model by one transaction; return its response.
   function automatic rsp_type lookup_or_store(input probe_req_type r);
      rsp_type     res;
      logic [31:0] tag;
      int          base;
      int          victim;
      int          s;
      int          c;
      logic [14:0] dep;
      logic [15:0] mv;
      res = '0;
      tag = r.key[63:32];
      base = int'(r.key[SetBits-1:0]) * Ways;
      if (r.action == ACT_PROBE) begin
         for (int w = 0; w < Ways; w++) begin
            s = base + w;
            if (tt_tag[s] == tag) begin
               res.found = 1'b1;
               res.score = tt_score[s];
               res.bound = tt_bound[s];
               res.depth = tt_depth[s];
               res.move = tt_move[s];
               res.eval = tt_eval[s];
               res.age = tt_age[s];
               return res;
            end
         end
         return res;
      end
      dep = r.depth[15] ? 15'd0 : r.depth[14:0];
      mv = r.move;
      victim = base;
      for (int w = 0; w < Ways; w++) begin
         s = base + w;
         if (tt_tag[s] == 32'd0 || tt_tag[s] == tag) begin
            if (mv == 16'd0) mv = tt_move[s];
            victim = s;
            break;
         end
         c = (tt_age[victim] == generation) ? 2 : 0;
         c += (tt_age[s] == generation || tt_bound[s] == BOUND_EXACT) ? -2 : 0;
         c += (tt_depth[s] < tt_depth[victim]) ? 1 : 0;
         if (c > 0) victim = s;
      end
      tt_tag[victim] = tag;
      tt_depth[victim] = dep;
      tt_bound[victim] = r.bound;
      tt_age[victim] = generation;
      tt_move[victim] = mv;
      tt_score[victim] = r.score;
      tt_eval[victim] = r.eval;
      return res;
   endfunction

   // Drive one transaction, hold until accepted, then queue its expectation.
   task automatic push_request(input probe_req_type r, input bit has_fixed,
                               input rsp_type fixed);
      rsp_type want;
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_action <= r.action;
      req_position_key <= r.key;
      req_score_in <= r.score;
      req_bound_in <= r.bound;
      req_depth_in <= r.depth;
      req_move_in <= r.move;
      req_eval_in <= r.eval;
      do @(posedge clock); while (req_full);
      want = lookup_or_store(r);
      if (has_fixed && want != fixed) begin
         report_mismatch("typed-in expectation", fixed, want);
      end
      expected_rsps.push_back(want);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_generation(input logic [7:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 1'b0;
      pwdata <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      generation = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Keys pile onto a few clusters so that ways fill and victims get picked.
   function automatic probe_req_type random_request();
      probe_req_type r;
      r.action = $urandom_range(99) < 55 ? ACT_STORE : ACT_PROBE;
      r.key = {$urandom(), $urandom()};
      if ($urandom_range(3) != 0) r.key[SetBits-1:0] = SetBits'($urandom_range(7));
      if ($urandom_range(3) != 0) r.key[63:32] = 32'($urandom_range(11));
      r.score = 16'($urandom());
      r.bound = 2'($urandom());
      r.depth = $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(40));
      r.move = $urandom_range(4) == 0 ? 16'd0 : 16'($urandom());
      r.eval = 16'($urandom());
      return r;
   endfunction

   // Check each accepted response against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", RspW'(rsp_found), '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_found !== want.found)
               report_mismatch("found", RspW'(rsp_found), RspW'(want.found));
            if (rsp_score_out !== want.score)
               report_mismatch("score", RspW'($unsigned(rsp_score_out)),
                               RspW'(want.score));
            if (rsp_bound_out !== want.bound)
               report_mismatch("bound", RspW'(rsp_bound_out), RspW'(want.bound));
            if (rsp_depth_out !== want.depth)
               report_mismatch("depth", RspW'(rsp_depth_out), RspW'(want.depth));
            if (rsp_move_out !== want.move)
               report_mismatch("move", RspW'(rsp_move_out), RspW'(want.move));
            if (rsp_eval_out !== want.eval)
               report_mismatch("eval", RspW'($unsigned(rsp_eval_out)),
                               RspW'(want.eval));
            if (rsp_age_out !== want.age)
               report_mismatch("age", RspW'(rsp_age_out), RspW'(want.age));
         end
      end
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   // Bail out on a hung handshake.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit && !done) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      step_row_type rows[$];
      step_row_type row;
      probe_req_type r;
      rsp_type none;
      none = '0;
      for (int i = 0; i < NumSlots; i++) begin
         tt_tag[i] = '0; tt_depth[i] = '0; tt_bound[i] = '0; tt_age[i] = '0;
         tt_move[i] = '0; tt_score[i] = '0; tt_eval[i] = '0;
      end

      // Directed table: probes of a fresh table, extremes, zero-tag probe,
      // move keeping, depth clamp and a full cluster forcing replacement.
      r = '0; r.action = ACT_PROBE; r.key = 64'hFFFF_FFFF_FFFF_FFFF;
      row.req = r; row.has_fixed = 1; row.fixed = none; rows.push_back(row);
      r.key = 64'h0000_0000_0000_0FFF;  // zero tag hits the empty way 0
      row.req = r; row.fixed = '0; row.fixed.found = 1'b1; rows.push_back(row);
      r = '{ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF, 2'd3, 16'h7FFF, 16'hFFFF, 16'h8000};
      row.req = r; row.fixed = none; rows.push_back(row);
      r.action = ACT_PROBE;
      row.req = r; row.fixed = '{1'b1, 16'h7FFF, 2'd3, 15'h7FFF, 16'hFFFF, 16'h8000, 8'd0};
      rows.push_back(row);
      r = '{ACT_STORE, 64'hFFFF_FFFF_0000_0000, 16'h8000, 2'd0, 16'h8000, 16'h0001, 16'h7FFF};
      row.req = r; row.fixed = none; rows.push_back(row);
      r.move = 16'd0; r.depth = 16'hFFFF; r.bound = 2'd1;  // keep move, clamp depth
      row.req = r; row.has_fixed = 0; rows.push_back(row);
      r.action = ACT_PROBE;
      row.req = r; rows.push_back(row);
      for (int i = 1; i <= 6; i++) begin
         r = '{ACT_STORE, {32'(i), 32'h0000_0005}, 16'(i * 7), 2'(i), 16'(10 - i),
               16'(i), 16'(-i)};
         row.req = r; rows.push_back(row);
      end
      for (int i = 1; i <= 6; i++) begin
         r = '{ACT_PROBE, {32'(i), 32'h0000_0005}, 0, 0, 0, 0, 0};
         row.req = r; rows.push_back(row);
      end
      r = '{ACT_PROBE, 64'h0000_0000_0000_0005, 0, 0, 0, 0, 0};  // zero tag, full cluster
      row.req = r; rows.push_back(row);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_generation(8'd0);

      push_idle_pct = 22;
      pop_idle_pct = 63;
      foreach (rows[i]) push_request(rows[i].req, rows[i].has_fixed, rows[i].fixed);
      wait_drained();

      // Random phases, each preceded by a generation write, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_generation(8'd255);
            1: write_generation(8'd1);
            2: write_generation(8'($urandom()));
            3: write_generation(8'd0);
            4: write_generation(8'd128);
            default: write_generation(8'd255);
         endcase
         push_idle_pct = (phase < 2) ? 22 : (phase < 4) ? 63 : 0;
         pop_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 22 : 0;
         for (int n = 0; n < RandomItems / 6; n++) begin
            push_request(random_request(), 1'b0, none);
            // Pause the sender once until everything has drained.
            if (phase == 1 && n == 50) begin
               req_push <= 1'b0;
               while (expected_rsps.size() != 0) @(posedge clock);
            end
         end
         wait_drained();
      end

      done = 1'b1;
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
